// ----- rtl/jpi_pkg.sv -----
// Shared types, widths, register indexes and reset constants of the jog position integrator.
// Used by every module in this folder; depends on nothing else.
package jpi_pkg;

    localparam int POS_W  = 25;
    localparam int VEL_W  = 16;
    localparam int GAIN_W = 24;
    localparam int LEG_W  = 2;
    localparam int NUM_AXES = 3;
    localparam int FRAC_SHIFT = 15;
    localparam int PROD_W = VEL_W + GAIN_W + 1;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = POS_W;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [VEL_W-1:0] t_vel;
    typedef logic [GAIN_W-1:0]       t_gain;
    typedef logic [LEG_W-1:0]        t_leg;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TWO_LEG_MODE = 3'd0,
        REG_STEP_GAIN    = 3'd1,
        REG_X_MIN        = 3'd2,
        REG_X_MAX        = 3'd3,
        REG_Y_MIN        = 3'd4,
        REG_Y_MAX        = 3'd5,
        REG_Z_MIN        = 3'd6,
        REG_Z_MAX        = 3'd7
    } t_reg_idx;

    localparam t_pos  LEFT_Y_OFFSET = 25'sd2130706;
    localparam t_gain GAIN_RST      = 24'd33554;
    localparam t_pos  XY_LIM_RST    = 25'sd2516582;
    localparam t_pos  Z_LIM_RST     = 25'sd1677722;
    localparam t_leg  LEG_SINGLE    = 2'd1;
    localparam t_leg  LEG_FIRST     = 2'd0;

    // Per-lane control for one cycle.
    typedef struct packed {
        logic  load_vel;
        logic  load_gain;
        t_gain gain;
        logic  tick;
        logic  clr;
        t_pos  home;
        t_pos  lo;
        t_pos  hi;
    } t_lane_ctl;

endpackage

// ----- rtl/jpi_axis_lane.sv -----
// One axis lane: holds the velocity, the registered per-tick step and the position.
// Depends on jpi_pkg.
module jpi_axis_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jpi_pkg::t_lane_ctl i_ctl,
    input  jpi_pkg::t_pos      i_rst_pos,
    input  jpi_pkg::t_vel      i_vel,
    output jpi_pkg::t_pos      o_adv
);

    jpi_pkg::t_vel r_vel;
    jpi_pkg::t_pos r_delta;
    jpi_pkg::t_pos r_pos;

    jpi_pkg::t_vel                       w_vel_op;
    logic signed [jpi_pkg::PROD_W-1:0]   w_prod;
    logic signed [jpi_pkg::POS_W:0]      w_sum;
    logic signed [jpi_pkg::POS_W:0]      w_lo;
    logic signed [jpi_pkg::POS_W:0]      w_hi;
    logic signed [jpi_pkg::POS_W:0]      w_raised;

    assign w_vel_op = i_ctl.load_vel ? i_vel : r_vel;
    assign w_prod   = $signed(w_vel_op) * $signed({1'b0, i_ctl.gain});

    // The product never exceeds 40 bits, so this select is the floor shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel   <= '0;
            r_delta <= '0;
        end else begin
            if (i_ctl.load_vel) begin
                r_vel <= i_vel;
            end
            if (i_ctl.load_vel || i_ctl.load_gain) begin
                r_delta <= w_prod[jpi_pkg::PROD_W-2:jpi_pkg::FRAC_SHIFT];
            end
        end
    end

    assign w_sum    = {r_pos[jpi_pkg::POS_W-1], r_pos} + {r_delta[jpi_pkg::POS_W-1], r_delta};
    assign w_lo     = {i_ctl.lo[jpi_pkg::POS_W-1], i_ctl.lo};
    assign w_hi     = {i_ctl.hi[jpi_pkg::POS_W-1], i_ctl.hi};
    assign w_raised = (w_sum < w_lo) ? w_lo : w_sum;
    assign o_adv    = (w_raised > w_hi) ? i_ctl.hi : w_raised[jpi_pkg::POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= i_rst_pos;
        end else begin
            priority if (i_ctl.clr) begin
                r_pos <= i_ctl.home;
            end else if (i_ctl.tick) begin
                r_pos <= o_adv;
            end
        end
    end

endmodule

// ----- rtl/jpi_ctrl.sv -----
// Configuration registers, button edge detection and leg index; drives the three axis lanes.
// Depends on jpi_pkg.
module jpi_ctrl #(
    parameter jpi_pkg::t_pos LEFT_Y_OFFSET = jpi_pkg::LEFT_Y_OFFSET
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jpi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [jpi_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_sample,
    input  logic                                i_tick,
    input  logic                                i_btn_reset,
    input  logic                                i_btn_next,
    input  logic                                i_btn_prev,
    output jpi_pkg::t_lane_ctl [jpi_pkg::NUM_AXES-1:0] o_lane_ctl,
    output jpi_pkg::t_leg                       o_leg
);

    logic          r_mode;
    jpi_pkg::t_gain r_gain;
    jpi_pkg::t_pos r_lo [jpi_pkg::NUM_AXES];
    jpi_pkg::t_pos r_hi [jpi_pkg::NUM_AXES];
    logic          r_last_reset;
    logic          r_last_next;
    logic          r_last_prev;
    jpi_pkg::t_leg r_leg;

    jpi_pkg::t_reg_idx w_idx;
    logic          w_mode_wr;
    logic          w_gain_wr;
    logic          w_rst_edge;
    logic          w_next_edge;
    logic          w_prev_edge;
    logic          w_clr_all;
    logic          w_clr_xz;
    jpi_pkg::t_pos w_y_home;
    jpi_pkg::t_leg w_leg_step;

    assign w_idx       = jpi_pkg::t_reg_idx'(i_cfg_idx);
    assign w_mode_wr   = i_cfg_we && (w_idx == jpi_pkg::REG_TWO_LEG_MODE);
    assign w_gain_wr   = i_cfg_we && (w_idx == jpi_pkg::REG_STEP_GAIN);
    assign w_rst_edge  = i_sample && i_btn_reset && !r_last_reset;
    assign w_next_edge = i_sample && r_mode && i_btn_next && !r_last_next;
    assign w_prev_edge = i_sample && r_mode && i_btn_prev && !r_last_prev;

    // Leg steps zero y; a mode write or reset edge zeroes y in two-leg mode, else loads the left-leg offset.
    assign w_clr_all = w_mode_wr || w_rst_edge || w_next_edge || w_prev_edge;
    assign w_clr_xz  = w_clr_all;
    always_comb begin
        if (w_mode_wr) begin
            w_y_home = i_cfg_data[0] ? '0 : LEFT_Y_OFFSET;
        end else begin
            w_y_home = r_mode ? '0 : LEFT_Y_OFFSET;
        end
    end

    assign w_leg_step = r_leg + (w_next_edge ? jpi_pkg::LEG_W'(1) : '0)
                              + (w_prev_edge ? jpi_pkg::LEG_W'(3) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_gain       <= jpi_pkg::GAIN_RST;
            r_lo[0]      <= -jpi_pkg::XY_LIM_RST;
            r_hi[0]      <= jpi_pkg::XY_LIM_RST;
            r_lo[1]      <= -jpi_pkg::XY_LIM_RST;
            r_hi[1]      <= jpi_pkg::XY_LIM_RST;
            r_lo[2]      <= -jpi_pkg::Z_LIM_RST;
            r_hi[2]      <= jpi_pkg::Z_LIM_RST;
            r_last_reset <= 1'b0;
            r_last_next  <= 1'b0;
            r_last_prev  <= 1'b0;
            r_leg        <= jpi_pkg::LEG_SINGLE;
        end else begin
            if (i_cfg_we) begin
                unique case (w_idx)
                    jpi_pkg::REG_TWO_LEG_MODE: begin
                        r_mode <= i_cfg_data[0];
                        r_leg  <= i_cfg_data[0] ? jpi_pkg::LEG_FIRST : jpi_pkg::LEG_SINGLE;
                    end
                    jpi_pkg::REG_STEP_GAIN: r_gain  <= i_cfg_data[jpi_pkg::GAIN_W-1:0];
                    jpi_pkg::REG_X_MIN:     r_lo[0] <= i_cfg_data;
                    jpi_pkg::REG_X_MAX:     r_hi[0] <= i_cfg_data;
                    jpi_pkg::REG_Y_MIN:     r_lo[1] <= i_cfg_data;
                    jpi_pkg::REG_Y_MAX:     r_hi[1] <= i_cfg_data;
                    jpi_pkg::REG_Z_MIN:     r_lo[2] <= i_cfg_data;
                    jpi_pkg::REG_Z_MAX:     r_hi[2] <= i_cfg_data;
                endcase
            end
            if (i_sample) begin
                r_last_reset <= i_btn_reset;
                r_last_next  <= i_btn_next;
                r_last_prev  <= i_btn_prev;
                r_leg        <= w_leg_step;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < jpi_pkg::NUM_AXES; i++) begin
            o_lane_ctl[i].load_vel  = i_sample;
            o_lane_ctl[i].load_gain = w_gain_wr;
            o_lane_ctl[i].gain      = w_gain_wr ? i_cfg_data[jpi_pkg::GAIN_W-1:0] : r_gain;
            o_lane_ctl[i].tick      = i_tick;
            o_lane_ctl[i].clr       = w_clr_xz;
            o_lane_ctl[i].home      = '0;
            o_lane_ctl[i].lo        = r_lo[i];
            o_lane_ctl[i].hi        = r_hi[i];
        end
        o_lane_ctl[1].clr  = w_clr_all;
        o_lane_ctl[1].home = (w_mode_wr || w_rst_edge) ? w_y_home : '0;
    end

    assign o_leg = r_leg;

endmodule

// ----- rtl/jpi_out_stage.sv -----
// Output register that merges the three lane results and the leg index into one result item.
// Depends on jpi_pkg.
module jpi_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tick,
    input  jpi_pkg::t_pos                     i_x,
    input  jpi_pkg::t_pos                     i_y,
    input  jpi_pkg::t_pos                     i_z,
    input  jpi_pkg::t_leg                     i_leg,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [jpi_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_in_ready
);

    logic                          r_valid;
    logic [jpi_pkg::M_TDATA_W-1:0] r_data;

    assign o_in_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tick || (r_valid && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_data <= {3'b000, i_leg, i_z, i_y, i_x};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

// ----- rtl/jog_position_integrator.sv -----
// Top level of the jog position integrator: three axis lanes, control and output stage.
// Depends on jpi_pkg, jpi_ctrl, jpi_axis_lane and jpi_out_stage.
//
// Input items arrive on the s-side stream. tuser bit 0 is the command (0 joystick sample,
// 1 timer tick) and bit 1 marks a usable sample. A sample updates the held velocities and
// the button history and returns nothing; a tick moves each axis by its step, clamps it
// and returns one item on the m-side stream.
// One input item is taken every cycle while the input side is ready. A tick's result is in
// the output register in the cycle after it is accepted. The step of each axis is multiplied
// out when a sample or a gain write arrives, so a tick is only an add and a clamp in each lane.
// The input side is ready whenever the output register is empty or being read. When the
// receiver stalls, the result waits and the input side stops until it is taken.
// After reset the gain and limits hold their defaults, the block is in single-leg mode on
// leg 1, y sits at the left-leg offset and x and z at zero. Configuration writes take
// effect at the next clock edge and may only be issued while no item is in flight.
// Writing the mode register returns the targets and the leg index to their start values.
module jog_position_integrator #(
    parameter jpi_pkg::t_pos LEFT_Y_OFFSET = jpi_pkg::LEFT_Y_OFFSET
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // stick_x, stick_y, stick_z, btn_reset, btn_next_leg, btn_prev_leg, zero padding
    input  logic [jpi_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // command, msg_valid
    input  logic [jpi_pkg::S_TUSER_W-1:0]      i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_x, out_y, out_z, out_leg, zero padding
    output logic [jpi_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [jpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [jpi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    jpi_pkg::t_lane_ctl [jpi_pkg::NUM_AXES-1:0] w_lane_ctl;
    jpi_pkg::t_pos      w_adv [jpi_pkg::NUM_AXES];
    jpi_pkg::t_vel      w_vel [jpi_pkg::NUM_AXES];
    jpi_pkg::t_pos      w_rst_pos [jpi_pkg::NUM_AXES];
    jpi_pkg::t_leg      w_leg;
    logic               w_accept;
    logic               w_tick;
    logic               w_sample;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_tick   = w_accept && i_s_tuser[0];
    assign w_sample = w_accept && !i_s_tuser[0] && i_s_tuser[1];

    assign w_vel[0] = i_s_tdata[15:0];
    assign w_vel[1] = i_s_tdata[31:16];
    assign w_vel[2] = i_s_tdata[47:32];

    assign w_rst_pos[0] = '0;
    assign w_rst_pos[1] = LEFT_Y_OFFSET;
    assign w_rst_pos[2] = '0;

    jpi_ctrl #(
        .LEFT_Y_OFFSET (LEFT_Y_OFFSET)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (w_sample),
        .i_tick      (w_tick),
        .i_btn_reset (i_s_tdata[48]),
        .i_btn_next  (i_s_tdata[49]),
        .i_btn_prev  (i_s_tdata[50]),
        .o_lane_ctl  (w_lane_ctl),
        .o_leg       (w_leg)
    );

    for (genvar g = 0; g < jpi_pkg::NUM_AXES; g++) begin : g_lane
        jpi_axis_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_lane_ctl[g]),
            .i_rst_pos (w_rst_pos[g]),
            .i_vel     (w_vel[g]),
            .o_adv     (w_adv[g])
        );
    end

    jpi_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_x        (w_adv[0]),
        .i_y        (w_adv[1]),
        .i_z        (w_adv[2]),
        .i_leg      (w_leg),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_in_ready (o_s_tready)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for jog_position_integrator: joystick samples and ticks go in on
// the input stream, and a predictor of the integrator checks every result item.
// Depends on jpi_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic          tick;
        logic          usable;
        jpi_pkg::t_vel vx;
        jpi_pkg::t_vel vy;
        jpi_pkg::t_vel vz;
        logic          b_rst;
        logic          b_next;
        logic          b_prev;
    } t_jog_item;

    typedef struct packed {
        jpi_pkg::t_pos x;
        jpi_pkg::t_pos y;
        jpi_pkg::t_pos z;
        jpi_pkg::t_leg leg;
    } t_pose;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [jpi_pkg::S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [jpi_pkg::S_TUSER_W-1:0]  i_s_tuser = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [jpi_pkg::M_TDATA_W-1:0]  o_m_tdata;
    logic                           i_cfg_we = 1'b0;
    logic [jpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [jpi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    jog_position_integrator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted state of the integrator.
    logic           two_leg_q;
    jpi_pkg::t_gain gain_q;
    jpi_pkg::t_pos  lo_q [3];
    jpi_pkg::t_pos  hi_q [3];
    longint         pos_q [3];
    jpi_pkg::t_vel  vel_q [3];
    jpi_pkg::t_leg  leg_q;
    logic           last_rst_q;
    logic           last_next_q;
    logic           last_prev_q;

    t_pose expected_poses [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req = 0;
    logic lvl_rst = 1'b0;
    logic lvl_next = 1'b0;
    logic lvl_prev = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random ready, plus a long hold-off on request.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_error(input string msg);
        if (error_count < 50) $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Values at the falling edge are those sampled at the next rising edge.
    always @(negedge i_clk) begin
        t_pose got;
        t_pose want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[24:0];
            got.y = o_m_tdata[49:25];
            got.z = o_m_tdata[74:50];
            got.leg = o_m_tdata[76:75];
            if (expected_poses.size() == 0) begin
                report_error("result item with no pending tick");
            end else begin
                want = expected_poses.pop_front();
                if (got.x !== want.x)
                    report_error($sformatf("out_x %0d, expected %0d", got.x, want.x));
                if (got.y !== want.y)
                    report_error($sformatf("out_y %0d, expected %0d", got.y, want.y));
                if (got.z !== want.z)
                    report_error($sformatf("out_z %0d, expected %0d", got.z, want.z));
                if (got.leg !== want.leg)
                    report_error($sformatf("out_leg %0d, expected %0d", got.leg, want.leg));
            end
        end
    end

    function automatic void home_targets();
        pos_q[0] = 0;
        pos_q[2] = 0;
        pos_q[1] = two_leg_q ? 0 : jpi_pkg::LEFT_Y_OFFSET;
        leg_q = two_leg_q ? jpi_pkg::LEG_FIRST : jpi_pkg::LEG_SINGLE;
    endfunction

    function automatic void zero_targets();
        pos_q[0] = 0;
        pos_q[1] = 0;
        pos_q[2] = 0;
    endfunction

    function automatic longint advance_axis(longint pos, jpi_pkg::t_vel vel,
                                            jpi_pkg::t_pos lo, jpi_pkg::t_pos hi);
        longint prod;
        longint next_pos;
        prod = longint'(vel) * longint'(gain_q);
        next_pos = pos + (prod >>> jpi_pkg::FRAC_SHIFT);
        if (next_pos < lo) next_pos = lo;
        if (next_pos > hi) next_pos = hi;
        return next_pos;
    endfunction

    function automatic void integrate_item(t_jog_item it);
        t_pose pose;
        if (!it.tick) begin
            if (!it.usable) return;
            vel_q[0] = it.vx;
            vel_q[1] = it.vy;
            vel_q[2] = it.vz;
            if (it.b_rst && !last_rst_q) begin
                pos_q[0] = 0;
                pos_q[2] = 0;
                pos_q[1] = two_leg_q ? 0 : jpi_pkg::LEFT_Y_OFFSET;
            end
            last_rst_q = it.b_rst;
            if (two_leg_q) begin
                if (it.b_next && !last_next_q) begin
                    leg_q = leg_q + 2'd1;
                    zero_targets();
                end
                if (it.b_prev && !last_prev_q) begin
                    leg_q = leg_q - 2'd1;
                    zero_targets();
                end
            end
            last_next_q = it.b_next;
            last_prev_q = it.b_prev;
            return;
        end
        for (int i = 0; i < jpi_pkg::NUM_AXES; i++)
            pos_q[i] = advance_axis(pos_q[i], vel_q[i], lo_q[i], hi_q[i]);
        pose.x = jpi_pkg::t_pos'(pos_q[0]);
        pose.y = jpi_pkg::t_pos'(pos_q[1]);
        pose.z = jpi_pkg::t_pos'(pos_q[2]);
        pose.leg = leg_q;
        expected_poses.push_back(pose);
    endfunction

    function automatic void apply_reg_write(jpi_pkg::t_reg_idx idx,
                                            logic [jpi_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            jpi_pkg::REG_TWO_LEG_MODE: begin
                two_leg_q = data[0];
                home_targets();
            end
            jpi_pkg::REG_STEP_GAIN: gain_q = data[jpi_pkg::GAIN_W-1:0];
            jpi_pkg::REG_X_MIN:     lo_q[0] = jpi_pkg::t_pos'(data);
            jpi_pkg::REG_X_MAX:     hi_q[0] = jpi_pkg::t_pos'(data);
            jpi_pkg::REG_Y_MIN:     lo_q[1] = jpi_pkg::t_pos'(data);
            jpi_pkg::REG_Y_MAX:     hi_q[1] = jpi_pkg::t_pos'(data);
            jpi_pkg::REG_Z_MIN:     lo_q[2] = jpi_pkg::t_pos'(data);
            jpi_pkg::REG_Z_MAX:     hi_q[2] = jpi_pkg::t_pos'(data);
            default: ;
        endcase
    endfunction

    task automatic send_item(input t_jog_item it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {5'b0, it.b_prev, it.b_next, it.b_rst, it.vz, it.vy, it.vx};
        i_s_tuser <= {it.usable, it.tick};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
        integrate_item(it);
    endtask

    task automatic send_sample(input logic usable, input int vx, input int vy, input int vz,
                               input logic b_rst, input logic b_next, input logic b_prev);
        t_jog_item it;
        it.tick = 1'b0;
        it.usable = usable;
        it.vx = jpi_pkg::t_vel'(vx);
        it.vy = jpi_pkg::t_vel'(vy);
        it.vz = jpi_pkg::t_vel'(vz);
        it.b_rst = b_rst;
        it.b_next = b_next;
        it.b_prev = b_prev;
        send_item(it);
    endtask

    task automatic send_tick();
        t_jog_item it;
        it = '0;
        it.tick = 1'b1;
        send_item(it);
    endtask

    // Stops offering items and waits until the block has drained.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input jpi_pkg::t_reg_idx idx,
                             input logic [jpi_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
    endtask

    task automatic write_settings(input logic two_leg, input jpi_pkg::t_gain gain,
                                  input jpi_pkg::t_pos xl, input jpi_pkg::t_pos xh,
                                  input jpi_pkg::t_pos yl, input jpi_pkg::t_pos yh,
                                  input jpi_pkg::t_pos zl, input jpi_pkg::t_pos zh);
        wait_idle();
        write_reg(jpi_pkg::REG_TWO_LEG_MODE, {{(jpi_pkg::CFG_DATA_W-1){1'b0}}, two_leg});
        write_reg(jpi_pkg::REG_STEP_GAIN, {1'b0, gain});
        write_reg(jpi_pkg::REG_X_MIN, xl);
        write_reg(jpi_pkg::REG_X_MAX, xh);
        write_reg(jpi_pkg::REG_Y_MIN, yl);
        write_reg(jpi_pkg::REG_Y_MAX, yh);
        write_reg(jpi_pkg::REG_Z_MIN, zl);
        write_reg(jpi_pkg::REG_Z_MAX, zh);
        i_cfg_we <= 1'b0;
    endtask

    function automatic jpi_pkg::t_vel rand_vel();
        case ($urandom_range(3))
            0: return jpi_pkg::t_vel'(int'($urandom_range(128)) - 64);
            1: return $urandom_range(1) ? jpi_pkg::t_vel'(32767) : jpi_pkg::t_vel'(-32768);
            default: return jpi_pkg::t_vel'($urandom);
        endcase
    endfunction

    function automatic t_jog_item rand_item();
        t_jog_item it;
        it.tick = 1'($urandom_range(1));
        it.usable = ($urandom_range(99) < 92);
        it.vx = rand_vel();
        it.vy = rand_vel();
        it.vz = rand_vel();
        if (!it.tick && it.usable) begin
            if ($urandom_range(99) < 8) lvl_rst = !lvl_rst;
            if ($urandom_range(99) < 15) lvl_next = !lvl_next;
            if ($urandom_range(99) < 15) lvl_prev = !lvl_prev;
            it.b_rst = lvl_rst;
            it.b_next = lvl_next;
            it.b_prev = lvl_prev;
        end else begin
            it.b_rst = 1'($urandom_range(1));
            it.b_next = 1'($urandom_range(1));
            it.b_prev = 1'($urandom_range(1));
        end
        return it;
    endfunction

    // Limits are mostly ordered; now and then they stay crossed.
    task automatic random_settings(input logic two_leg, input logic wide_gain);
        jpi_pkg::t_pos a [3];
        jpi_pkg::t_pos b [3];
        jpi_pkg::t_pos tmp;
        jpi_pkg::t_gain gain;
        for (int i = 0; i < jpi_pkg::NUM_AXES; i++) begin
            a[i] = jpi_pkg::t_pos'($urandom);
            b[i] = jpi_pkg::t_pos'($urandom);
            if ($urandom_range(3) != 0 && a[i] > b[i]) begin
                tmp = a[i];
                a[i] = b[i];
                b[i] = tmp;
            end
        end
        gain = wide_gain ? jpi_pkg::t_gain'($urandom)
                         : jpi_pkg::t_gain'($urandom_range(1 << 20));
        write_settings(two_leg, gain, a[0], b[0], a[1], b[1], a[2], b[2]);
    endtask

    task automatic test_defaults();
        send_tick();
        send_sample(1'b1, 32767, -32768, 32767, 1'b0, 1'b0, 1'b0);
        send_tick();
        send_tick();
        send_sample(1'b0, -32768, 32767, -32768, 1'b1, 1'b1, 1'b1);
        send_tick();
        send_sample(1'b1, -32768, 32767, -32768, 1'b0, 1'b1, 1'b1);
        send_tick();
        send_sample(1'b1, 0, 0, 0, 1'b1, 1'b0, 1'b0);
        send_tick();
        send_sample(1'b1, 1, -1, 0, 1'b1, 1'b0, 1'b0);
        send_tick();
    endtask

    task automatic test_leg_cycling();
        write_settings(1'b1, jpi_pkg::t_gain'(24'hFFFFFF), jpi_pkg::t_pos'(-16777216),
                       jpi_pkg::t_pos'(16777215), jpi_pkg::t_pos'(-16777216),
                       jpi_pkg::t_pos'(16777215), jpi_pkg::t_pos'(-16777216),
                       jpi_pkg::t_pos'(16777215));
        send_sample(1'b1, 32767, -32768, 1, 1'b0, 1'b0, 1'b0);
        send_tick();
        send_tick();
        send_sample(1'b1, 32767, 0, 0, 1'b0, 1'b1, 1'b0);
        send_tick();
        send_sample(1'b1, 32767, 0, 0, 1'b0, 1'b1, 1'b1);
        send_tick();
        send_sample(1'b1, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, -32768, 32767, -32768, 1'b0, 1'b1, 1'b1);
        send_tick();
        send_sample(1'b1, -32768, 32767, -32768, 1'b0, 1'b0, 1'b1);
        send_sample(1'b1, -32768, 32767, -32768, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, -32768, 32767, -32768, 1'b0, 1'b0, 1'b1);
        send_tick();
        send_sample(1'b1, 100, 100, 100, 1'b1, 1'b0, 1'b0);
        send_tick();
    endtask

    task automatic test_crossed_limits();
        write_settings(1'b0, jpi_pkg::t_gain'(0), jpi_pkg::t_pos'(1000),
                       jpi_pkg::t_pos'(-1000), jpi_pkg::t_pos'(16777215),
                       jpi_pkg::t_pos'(-16777216), jpi_pkg::t_pos'(-5), jpi_pkg::t_pos'(-6));
        send_tick();
        send_sample(1'b1, 32767, 32767, 32767, 1'b0, 1'b0, 1'b0);
        send_tick();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) send_item(rand_item());
    endtask

    task automatic test_backpressure();
        t_jog_item it;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 300;
        for (int n = 0; n < 40; n++) begin
            it = rand_item();
            it.tick = (n % 2 == 1) ? 1'b1 : it.tick;
            send_item(it);
        end
        wait_idle();
        for (int n = 0; n < 20; n++) send_item(rand_item());
    endtask

    initial begin
        two_leg_q = 1'b0;
        gain_q = jpi_pkg::GAIN_RST;
        lo_q[0] = -jpi_pkg::XY_LIM_RST;
        hi_q[0] = jpi_pkg::XY_LIM_RST;
        lo_q[1] = -jpi_pkg::XY_LIM_RST;
        hi_q[1] = jpi_pkg::XY_LIM_RST;
        lo_q[2] = -jpi_pkg::Z_LIM_RST;
        hi_q[2] = jpi_pkg::Z_LIM_RST;
        for (int i = 0; i < jpi_pkg::NUM_AXES; i++) vel_q[i] = '0;
        last_rst_q = 1'b0;
        last_next_q = 1'b0;
        last_prev_q = 1'b0;
        home_targets();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_leg_cycling();
        test_crossed_limits();
        random_settings(1'b1, 1'b0);
        test_random(400, 31, 68);
        random_settings(1'b0, 1'b1);
        test_random(400, 68, 31);
        random_settings(1'b1, 1'b1);
        test_random(200, 0, 0);
        write_settings(1'b1, jpi_pkg::t_gain'($urandom_range(1 << 18)),
                       jpi_pkg::t_pos'(-16777216), jpi_pkg::t_pos'(16777215),
                       jpi_pkg::t_pos'(-16777216), jpi_pkg::t_pos'(16777215),
                       jpi_pkg::t_pos'(-16777216), jpi_pkg::t_pos'(16777215));
        test_random(200, 0, 0);
        test_backpressure();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/jpi_pkg.sv
rtl/jpi_axis_lane.sv
rtl/jpi_ctrl.sv
rtl/jpi_out_stage.sv
rtl/jog_position_integrator.sv
test/tb.sv
